// File: src/bbrs_pkg.sv
// bbrs_pkg: shared types and codes for the budgeted best-ratio selector
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package bbrs_pkg;

	localparam logic [1:0] CMD_OFFER   = 2'd0;
	localparam logic [1:0] CMD_CONSUME = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	localparam logic [1:0] RK_CHOICE  = 2'd0;
	localparam logic [1:0] RK_CONSUME = 2'd1;
	localparam logic [1:0] RK_CLEAR   = 2'd2;

	localparam logic [1:0] CFG_TEST_LIMIT    = 2'd0;
	localparam logic [1:0] CFG_COST_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_LATENCY_LIMIT = 2'd2;

	localparam int unsigned NUM_W  = 48;
	localparam int unsigned HALF_W = 24;
	localparam int unsigned DEN_W  = 32;
	localparam int unsigned PP_W   = HALF_W + DEN_W;
	localparam int unsigned XP_W   = NUM_W + DEN_W;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] candidate_id;
		logic [15:0] uncertainty_gain;
		logic [15:0] discrimination;
		logic [15:0] reliability;
		logic [31:0] cost;
		logic [31:0] latency_ms;
		logic        last_offer;
	} req_t;

	typedef struct packed {
		logic [1:0]  reply_kind;
		logic [31:0] chosen_id;
		logic        found;
		logic        accepted;
	} rsp_t;

	typedef enum logic [1:0] {
		K_OFFER,
		K_CONSUME,
		K_CLEAR
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] id;
		logic [31:0] gd;
		logic [15:0] rel;
		logic [31:0] cost;
		logic [31:0] den;
		logic [31:0] lat;
		logic        last;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_XHI,
		ST_XLO,
		ST_CMP,
		ST_RPT,
		ST_CONS,
		ST_CLR
	} st_t;

endpackage

// File: src/bbrs_front.sv
// bbrs_front: takes request words, decodes the command, forms the first
// product and floored cost; depends on bbrs_pkg
`timescale 1ns / 1ps

module bbrs_front (
	input  logic           req_valid,
	output logic           req_ready,
	input  bbrs_pkg::req_t req,
	input  logic           q_full,
	output logic           q_push,
	output bbrs_pkg::item_t q_item
);

	logic known;

	always_comb begin
		known = 1'b1;
		q_item.kind = bbrs_pkg::K_OFFER;
		case (req.command)
			bbrs_pkg::CMD_OFFER: begin
				q_item.kind = bbrs_pkg::K_OFFER;
			end
			bbrs_pkg::CMD_CONSUME: begin
				q_item.kind = bbrs_pkg::K_CONSUME;
			end
			bbrs_pkg::CMD_CLEAR: begin
				q_item.kind = bbrs_pkg::K_CLEAR;
			end
			default: begin
				known = 1'b0;
			end
		endcase
		q_item.id   = req.candidate_id;
		q_item.gd   = req.uncertainty_gain * req.discrimination;
		q_item.rel  = req.reliability;
		q_item.cost = req.cost;
		q_item.den  = (req.cost == 32'd0) ? 32'd1 : req.cost;
		q_item.lat  = req.latency_ms;
		q_item.last = req.last_offer;
	end

	// unknown commands are taken and dropped
	assign req_ready = !q_full;
	assign q_push    = req_valid && !q_full && known;

endmodule

// File: src/bbrs_queue.sv
// bbrs_queue: short first-in first-out queue of decoded items between
// front and back; depends on bbrs_pkg
`timescale 1ns / 1ps

module bbrs_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bbrs_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output bbrs_pkg::item_t pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bbrs_pkg::item_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: src/bbrs_back.sv
// bbrs_back: sequencer that runs one item at a time, holds the test and cost limits,
// usage counters, running best and the reply register; depends on bbrs_pkg
`timescale 1ns / 1ps

module bbrs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [1:0]      cfg_index,
	input  logic [47:0]     cfg_data,
	input  logic            q_valid,
	input  bbrs_pkg::item_t q_item,
	output logic            q_pop,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bbrs_pkg::rsp_t  rsp
);

	bbrs_pkg::st_t st_q;
	bbrs_pkg::st_t st_d;

	logic [31:0] test_limit_q;
	logic [47:0] cost_limit_q;
	logic [31:0] tests_spent_q;
	logic [47:0] cost_spent_q;
	logic [47:0] latency_spent_q;
	logic [47:0] best_num_q;
	logic [31:0] best_cost_q;
	logic [31:0] best_id_q;
	logic        best_valid_q;
	logic        rsp_valid_q;
	bbrs_pkg::rsp_t rsp_q;

	bbrs_pkg::item_t item_q;
	logic                        fits_q;
	logic [bbrs_pkg::NUM_W-1:0]  num_q;
	logic [bbrs_pkg::PP_W-1:0]   ahi_q;
	logic [bbrs_pkg::PP_W-1:0]   bhi_q;
	logic [bbrs_pkg::XP_W-1:0]   ax_q;
	logic [bbrs_pkg::XP_W-1:0]   bx_q;

	logic [bbrs_pkg::NUM_W-1:0]  num_d;
	logic [48:0]                 room;
	logic                        fits_d;
	logic [bbrs_pkg::PP_W-1:0]   alo;
	logic [bbrs_pkg::PP_W-1:0]   blo;
	logic                        take;
	logic                        report_ok;
	logic                        consume_ok;
	logic [48:0]                 cost_sum;
	logic [48:0]                 lat_sum;
	logic                        emit;
	bbrs_pkg::rsp_t              rsp_d;

	assign num_d  = item_q.gd * item_q.rel;
	assign room   = {1'b0, cost_limit_q} - {1'b0, cost_spent_q};
	assign fits_d = !room[48] && ({16'd0, item_q.cost} <= room[47:0]);
	assign alo    = num_q[bbrs_pkg::HALF_W-1:0] * best_cost_q;
	assign blo    = best_num_q[bbrs_pkg::HALF_W-1:0] * item_q.den;
	assign take   = fits_q && (!best_valid_q || (ax_q > bx_q));

	assign report_ok  = best_valid_q && (tests_spent_q < test_limit_q);
	assign cost_sum   = {1'b0, cost_spent_q} + {17'd0, item_q.cost};
	assign consume_ok = (tests_spent_q < test_limit_q) && (cost_sum <= {1'b0, cost_limit_q});
	assign lat_sum    = {1'b0, latency_spent_q} + {17'd0, item_q.lat};

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			bbrs_pkg::ST_IDLE: begin
				if (q_pop) begin
					case (q_item.kind)
						bbrs_pkg::K_OFFER:   st_d = bbrs_pkg::ST_MUL;
						bbrs_pkg::K_CONSUME: st_d = bbrs_pkg::ST_CONS;
						bbrs_pkg::K_CLEAR:   st_d = bbrs_pkg::ST_CLR;
						default:             st_d = bbrs_pkg::ST_IDLE;
					endcase
				end
			end
			bbrs_pkg::ST_MUL: st_d = bbrs_pkg::ST_XHI;
			bbrs_pkg::ST_XHI: st_d = bbrs_pkg::ST_XLO;
			bbrs_pkg::ST_XLO: st_d = bbrs_pkg::ST_CMP;
			bbrs_pkg::ST_CMP: st_d = item_q.last ? bbrs_pkg::ST_RPT : bbrs_pkg::ST_IDLE;
			default:          st_d = bbrs_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop = 1'b0;
		emit  = 1'b0;
		rsp_d = '0;
		case (st_q)
			bbrs_pkg::ST_IDLE: begin
				q_pop = q_valid && (!rsp_valid_q || rsp_ready);
			end
			bbrs_pkg::ST_RPT: begin
				emit             = 1'b1;
				rsp_d.reply_kind = bbrs_pkg::RK_CHOICE;
				rsp_d.chosen_id  = report_ok ? best_id_q : 32'd0;
				rsp_d.found      = report_ok;
			end
			bbrs_pkg::ST_CONS: begin
				emit             = 1'b1;
				rsp_d.reply_kind = bbrs_pkg::RK_CONSUME;
				rsp_d.accepted   = consume_ok;
			end
			bbrs_pkg::ST_CLR: begin
				emit             = 1'b1;
				rsp_d.reply_kind = bbrs_pkg::RK_CLEAR;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q            <= bbrs_pkg::ST_IDLE;
			test_limit_q    <= '0;
			cost_limit_q    <= '0;
			tests_spent_q   <= '0;
			cost_spent_q    <= '0;
			latency_spent_q <= '0;
			best_num_q      <= '0;
			best_cost_q     <= '0;
			best_id_q       <= '0;
			best_valid_q    <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			st_q <= st_d;
			// latency limit writes are dropped: no register here holds it
			if (cfg_valid) begin
				case (cfg_index)
					bbrs_pkg::CFG_TEST_LIMIT: test_limit_q <= cfg_data[31:0];
					bbrs_pkg::CFG_COST_LIMIT: cost_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if ((st_q == bbrs_pkg::ST_CMP) && take) begin
				best_num_q   <= num_q;
				best_cost_q  <= item_q.den;
				best_id_q    <= item_q.id;
				best_valid_q <= 1'b1;
			end
			if (st_q == bbrs_pkg::ST_RPT) begin
				best_num_q   <= '0;
				best_cost_q  <= '0;
				best_id_q    <= '0;
				best_valid_q <= 1'b0;
			end
			if ((st_q == bbrs_pkg::ST_CONS) && consume_ok) begin
				tests_spent_q   <= tests_spent_q + 1'b1;
				cost_spent_q    <= cost_sum[47:0];
				latency_spent_q <= lat_sum[48] ? '1 : lat_sum[47:0];
			end
			if (st_q == bbrs_pkg::ST_CLR) begin
				tests_spent_q   <= '0;
				cost_spent_q    <= '0;
				latency_spent_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
		if (st_q == bbrs_pkg::ST_MUL) begin
			num_q  <= num_d;
			fits_q <= fits_d;
		end
		if (st_q == bbrs_pkg::ST_XHI) begin
			ahi_q <= num_q[bbrs_pkg::NUM_W-1:bbrs_pkg::HALF_W] * best_cost_q;
			bhi_q <= best_num_q[bbrs_pkg::NUM_W-1:bbrs_pkg::HALF_W] * item_q.den;
		end
		if (st_q == bbrs_pkg::ST_XLO) begin
			ax_q <= {ahi_q, {bbrs_pkg::HALF_W{1'b0}}} + {{bbrs_pkg::HALF_W{1'b0}}, alo};
			bx_q <= {bhi_q, {bbrs_pkg::HALF_W{1'b0}}} + {{bbrs_pkg::HALF_W{1'b0}}, blo};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/budgeted_best_ratio_selector_top.sv
// budgeted best-ratio selector: picks the best affordable candidate of an
// offer run by cross-multiplied ratio compare and keeps budget counters.
// request words go in on req, replies come out on rsp, limits are written on cfg.
// command offer feeds the running best; an offer with last_offer set gives a
// choice reply. consume charges the budget if it fits and replies with the
// verdict; clear zeroes the usage counters and replies. command 3 is dropped.
// a front stage decodes each word into a short queue; a back sequencer runs
// one queued item at a time. an offer is taken, then goes through states for the
// 32x16 product, the high and then the low halves of the split 24x32 cross
// products and the compare, then a report state if last_offer is set. consume and
// clear are taken, then handled in one state each. reset clears limits,
// counters, the running best and the queue.
// a stalled rsp holds its word; the back starts no new item until the reply
// register is free, and req stays ready while the queue has room.
`timescale 1ns / 1ps

module budgeted_best_ratio_selector_top #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bbrs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bbrs_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [47:0]    cfg_data
);

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	bbrs_pkg::item_t push_item;
	bbrs_pkg::item_t pop_item;

	assign cfg_ready = 1'b1;

	bbrs_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	bbrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (pop_item)
	);

	bbrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_pop_needs_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (!rsp_valid || rsp_ready)))
		else $error("item started while reply register busy");

	a_nop_not_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(req.command == bbrs_pkg::CMD_NOP) |-> !q_push)
		else $error("unknown command entered the queue");

	a_pop_gap: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop)
		else $error("back took two items in a row");

	a_reply_found_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.found) |-> (rsp.reply_kind == bbrs_pkg::RK_CHOICE && !rsp.accepted))
		else $error("found set outside a choice reply");
`endif

endmodule

// File: sim/budgeted_best_ratio_selector_top_test.sv
// testbench for budgeted_best_ratio_selector_top: a directed table then random offer runs,
// every reply checked against the table's expected reply or an in-bench model of the selector and its budget counters
// depends on src/bbrs_pkg.sv and src/budgeted_best_ratio_selector_top.sv
`timescale 1ns / 1ps

module budgeted_best_ratio_selector_top_test;
	import bbrs_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 32;
	localparam int PHASES       = 6;
	localparam int PHASE_WORDS  = 68;

	typedef struct {
		logic        is_reg;
		logic [1:0]  reg_index;
		logic [47:0] reg_data;
		req_t        w;
		logic        typed;
		rsp_t        reply;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_t        rsp;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	// model state
	logic [31:0] test_limit = '0;
	logic [47:0] cost_limit = '0;
	logic [47:0] latency_limit = '0;
	logic [31:0] tests_spent = '0;
	logic [47:0] cost_spent = '0;
	logic [47:0] latency_spent = '0;
	logic [47:0] best_num = '0;
	logic [31:0] best_den = '0;
	logic [31:0] best_id = '0;
	logic        best_valid = 1'b0;

	rsp_t pending_replies[$];
	row_t plan[$];

	int errors = 0;
	int cycle_count = 0;
	int req_idle_pct = 19;
	int rsp_idle_pct = 19;
	int n_words = 0;
	int n_choice = 0;
	int n_picked = 0;
	int n_consume = 0;
	int n_charged = 0;
	int n_clear = 0;

	budgeted_best_ratio_selector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// n1/d1 > n2/d2 by cross products
	function automatic logic ratio_beats(input logic [47:0] n1, input logic [31:0] d1,
			input logic [47:0] n2, input logic [31:0] d2);
		logic [79:0] lhs;
		logic [79:0] rhs;
		lhs = 80'(n1) * 80'(d2);
		rhs = 80'(n2) * 80'(d1);
		return lhs > rhs;
	endfunction

	function automatic void apply_register(input logic [1:0] idx, input logic [47:0] val);
		case (idx)
			CFG_TEST_LIMIT:    test_limit = val[31:0];
			CFG_COST_LIMIT:    cost_limit = val;
			CFG_LATENCY_LIMIT: latency_limit = val;
			default: ;
		endcase
	endfunction

	function automatic logic predict_reply(input req_t w, output rsp_t r);
		logic [47:0] num;
		logic [31:0] den;
		logic [48:0] lat_sum;
		logic        ok;
		r = '0;
		case (w.command)
			CMD_OFFER: begin
				if (cost_spent <= cost_limit && 48'(w.cost) <= cost_limit - cost_spent) begin
					num = 48'(w.uncertainty_gain) * 48'(w.discrimination) * 48'(w.reliability);
					den = (w.cost == '0) ? 32'd1 : w.cost;
					if (!best_valid || ratio_beats(num, den, best_num, best_den)) begin
						best_num = num;
						best_den = den;
						best_id = w.candidate_id;
						best_valid = 1'b1;
					end
				end
				if (!w.last_offer)
					return 1'b0;
				ok = best_valid && tests_spent < test_limit;
				r.reply_kind = RK_CHOICE;
				r.chosen_id = ok ? best_id : '0;
				r.found = ok;
				best_num = '0;
				best_den = '0;
				best_id = '0;
				best_valid = 1'b0;
				return 1'b1;
			end
			CMD_CONSUME: begin
				ok = tests_spent < test_limit
					&& 49'(cost_spent) + 49'(w.cost) <= 49'(cost_limit);
				if (ok) begin
					tests_spent = tests_spent + 1;
					cost_spent = cost_spent + 48'(w.cost);
					lat_sum = 49'(latency_spent) + 49'(w.latency_ms);
					latency_spent = lat_sum[48] ? '1 : lat_sum[47:0];
				end
				r.reply_kind = RK_CONSUME;
				r.accepted = ok;
				return 1'b1;
			end
			CMD_CLEAR: begin
				tests_spent = '0;
				cost_spent = '0;
				latency_spent = '0;
				r.reply_kind = RK_CLEAR;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic row_t word(input logic [1:0] cmd, input logic [31:0] id,
			input logic [15:0] g, input logic [15:0] d, input logic [15:0] r,
			input logic [31:0] cost, input logic [31:0] lat, input logic last);
		row_t x;
		x = '{is_reg: 1'b0, reg_index: '0, reg_data: '0, w: '0, typed: 1'b0, reply: '0};
		x.w.command = cmd;
		x.w.candidate_id = id;
		x.w.uncertainty_gain = g;
		x.w.discrimination = d;
		x.w.reliability = r;
		x.w.cost = cost;
		x.w.latency_ms = lat;
		x.w.last_offer = last;
		return x;
	endfunction

	function automatic row_t with_reply(input row_t x, input logic [1:0] kind,
			input logic [31:0] id, input logic found, input logic acc);
		row_t y;
		y = x;
		y.typed = 1'b1;
		y.reply = '{reply_kind: kind, chosen_id: id, found: found, accepted: acc};
		return y;
	endfunction

	function automatic row_t reg_write(input logic [1:0] idx, input logic [47:0] val);
		row_t x;
		x = '{is_reg: 1'b1, reg_index: idx, reg_data: val, w: '0, typed: 1'b0, reply: '0};
		return x;
	endfunction

	function automatic logic [15:0] rand_factor();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_cost();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom_range(32'h40000, 32'h800);
		endcase
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic req_t rand_word(input logic [1:0] cmd, input logic last);
		req_t w;
		w.command = cmd;
		w.candidate_id = $urandom;
		w.uncertainty_gain = rand_factor();
		w.discrimination = rand_factor();
		w.reliability = rand_factor();
		w.cost = rand_cost();
		w.latency_ms = ($urandom_range(3) == 0) ? '1 : $urandom;
		w.last_offer = last;
		return w;
	endfunction

	task automatic send_word(input req_t w, input logic typed, input rsp_t typed_reply);
		rsp_t r;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (!(req_valid && req_ready));
		n_words++;
		if (predict_reply(w, r))
			pending_replies.push_back(typed ? typed_reply : r);
	endtask

	// caller lowers cfg_valid once the last register of a series is written
	task automatic write_register(input logic [1:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		apply_register(idx, val);
	endtask

	task automatic set_limits(input logic [31:0] tl, input logic [47:0] cl,
			input logic [47:0] ll);
		write_register(CFG_TEST_LIMIT, 48'(tl));
		write_register(CFG_COST_LIMIT, cl);
		write_register(CFG_LATENCY_LIMIT, ll);
		cfg_valid <= 1'b0;
	endtask

	// offers without a reply may still be in the back end, so idle a while
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	// reply side
	always @(posedge clk) begin
		rsp_t want;
		cycle_count <= cycle_count + 1;
		rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected reply word, kind", 32'(rsp.reply_kind), '0);
			end else begin
				want = pending_replies.pop_front();
				if (rsp.reply_kind != want.reply_kind)
					report_mismatch("reply_kind", 32'(rsp.reply_kind), 32'(want.reply_kind));
				if (rsp.chosen_id != want.chosen_id)
					report_mismatch("chosen_id", rsp.chosen_id, want.chosen_id);
				if (rsp.found != want.found)
					report_mismatch("found", 32'(rsp.found), 32'(want.found));
				if (rsp.accepted != want.accepted)
					report_mismatch("accepted", 32'(rsp.accepted), 32'(want.accepted));
				case (want.reply_kind)
					RK_CHOICE: begin
						n_choice++;
						if (want.found)
							n_picked++;
					end
					RK_CONSUME: begin
						n_consume++;
						if (want.accepted)
							n_charged++;
					end
					default: n_clear++;
				endcase
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int   sent;
		int   roll;
		int   run_len;
		logic paused;

		// after reset every limit is zero
		plan.push_back(with_reply(word(CMD_OFFER, 32'd5, '1, '1, '1, 32'd1, '0, 1'b1),
			RK_CHOICE, '0, 1'b0, 1'b0));
		plan.push_back(with_reply(word(CMD_CONSUME, 32'd1, '0, '0, '0, '0, '0, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b0));
		plan.push_back(with_reply(word(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0),
			RK_CLEAR, '0, 1'b0, 1'b0));
		plan.push_back(word(CMD_NOP, '1, '1, '1, '1, '1, '1, 1'b1));
		plan.push_back(reg_write(CFG_TEST_LIMIT, 48'hffff_ffff));
		plan.push_back(reg_write(CFG_COST_LIMIT, '1));
		plan.push_back(reg_write(CFG_LATENCY_LIMIT, '1));
		// zero utility taken first, then beaten; zero cost floored
		plan.push_back(word(CMD_OFFER, '0, '0, '0, '0, '0, '0, 1'b0));
		plan.push_back(word(CMD_OFFER, '1, '1, '1, '1, '1, '1, 1'b0));
		plan.push_back(with_reply(word(CMD_OFFER, 32'd7, '1, '1, '1, '0, 32'd1, 1'b1),
			RK_CHOICE, 32'd7, 1'b1, 1'b0));
		plan.push_back(with_reply(word(CMD_OFFER, '0, '0, '0, '0, '0, '0, 1'b1),
			RK_CHOICE, '0, 1'b1, 1'b0));
		// tie keeps the earlier one
		plan.push_back(word(CMD_OFFER, 32'd10, 16'h100, 16'h100, 16'h100, 32'h10000,
			32'd5, 1'b0));
		plan.push_back(with_reply(word(CMD_OFFER, 32'd11, 16'h100, 16'h100, 16'h100,
			32'h10000, 32'd5, 1'b1), RK_CHOICE, 32'd10, 1'b1, 1'b0));
		plan.push_back(with_reply(word(CMD_CONSUME, '0, '0, '0, '0, '1, '1, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b1));
		// limit lowered under what is already spent
		plan.push_back(reg_write(CFG_COST_LIMIT, 48'h10000));
		plan.push_back(with_reply(word(CMD_OFFER, 32'd20, '1, '1, '1, '0, '0, 1'b1),
			RK_CHOICE, '0, 1'b0, 1'b0));
		plan.push_back(with_reply(word(CMD_CONSUME, '0, '0, '0, '0, '0, '0, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b0));
		plan.push_back(with_reply(word(CMD_CLEAR, '1, '1, '1, '1, '1, '1, 1'b1),
			RK_CLEAR, '0, 1'b0, 1'b0));
		// cost just over and just at the budget
		plan.push_back(word(CMD_OFFER, 32'd21, '1, '1, '1, 32'h10001, '0, 1'b0));
		plan.push_back(with_reply(word(CMD_OFFER, 32'd22, 16'd1, 16'd1, 16'd1, 32'h10000,
			'0, 1'b1), RK_CHOICE, 32'd22, 1'b1, 1'b0));
		plan.push_back(with_reply(word(CMD_CONSUME, '0, '0, '0, '0, 32'h10001, '0, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b0));
		plan.push_back(with_reply(word(CMD_CONSUME, '0, '0, '0, '0, 32'h10000, 32'd3, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b1));
		plan.push_back(with_reply(word(CMD_CONSUME, '0, '0, '0, '0, '0, '0, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b1));
		// test count exhausted
		plan.push_back(reg_write(CFG_TEST_LIMIT, 48'd2));
		plan.push_back(with_reply(word(CMD_CONSUME, '0, '0, '0, '0, '0, '0, 1'b0),
			RK_CONSUME, '0, 1'b0, 1'b0));
		plan.push_back(with_reply(word(CMD_OFFER, 32'd30, 16'd5, 16'd5, 16'd5, '0, '0, 1'b1),
			RK_CHOICE, '0, 1'b0, 1'b0));
		// clear in the middle of a run
		plan.push_back(word(CMD_OFFER, 32'd31, 16'h8000, 16'h8000, 16'h8000, 32'h2000,
			'0, 1'b0));
		plan.push_back(with_reply(word(CMD_CLEAR, '0, '0, '0, '0, '0, '0, 1'b0),
			RK_CLEAR, '0, 1'b0, 1'b0));
		plan.push_back(word(CMD_OFFER, 32'd32, 16'h4000, 16'hffff, 16'h1234, 32'h1000,
			'0, 1'b1));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].is_reg) begin
				if (i == 0 || !plan[i - 1].is_reg)
					wait_drained();
				write_register(plan[i].reg_index, plan[i].reg_data);
				if (i == plan.size() - 1 || !plan[i + 1].is_reg)
					cfg_valid <= 1'b0;
			end else begin
				send_word(plan[i].w, plan[i].typed, plan[i].reply);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: set_limits('1, '1, '1);
				1: set_limits('0, '0, '0);
				default: set_limits(
					($urandom_range(3) == 0) ? '1 : 32'($urandom_range(6, 1)),
					($urandom_range(3) == 0) ? rand48()
						: 48'($urandom_range(32'h400000, 32'h10000)),
					rand48());
			endcase
			req_idle_pct = (phase == 2) ? 0 : 19;
			rsp_idle_pct = (phase == 2) ? 0 : 19;
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_WORDS) begin
				// hold off the sender until every reply is back
				if (phase == 3 && !paused && sent >= PHASE_WORDS / 2) begin
					wait_drained();
					paused = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll < 72) begin
					run_len = $urandom_range(5, 1);
					for (int k = 0; k < run_len; k++) begin
						if ($urandom_range(99) < 8) begin
							send_word(rand_word(($urandom_range(1) == 0) ? CMD_CONSUME
								: CMD_CLEAR, 1'($urandom)), 1'b0, '0);
							sent++;
						end
						send_word(rand_word(CMD_OFFER, k == run_len - 1), 1'b0, '0);
						sent++;
					end
				end else if (roll < 88) begin
					send_word(rand_word(CMD_CONSUME, 1'($urandom)), 1'b0, '0);
					sent++;
				end else if (roll < 94) begin
					send_word(rand_word(CMD_CLEAR, 1'($urandom)), 1'b0, '0);
					sent++;
				end else if (roll < 97) begin
					send_word(rand_word(CMD_OFFER, 1'($urandom)), 1'b0, '0);
					sent++;
				end else begin
					send_word(rand_word(CMD_NOP, 1'($urandom)), 1'b0, '0);
				end
			end
		end

		wait_drained();
		$display("run covered %0d request words over %0d limit settings after the table",
			n_words, PHASES);
		$display("replies: %0d choices (%0d with a pick), %0d consumes (%0d charged), %0d clears",
			n_choice, n_picked, n_consume, n_charged, n_clear);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
